// ----- rtl/core/avts_pkg.sv -----
package avts_pkg;

   localparam int AUDIO_DEPTH = 16;
   localparam int VIDEO_DEPTH = 16;
   localparam int TAG_BITS    = 16;

   localparam int STAMP_W = 32;
   localparam int TAG_W   = 16;
   localparam int DELAY_W = 16;

   localparam int AUDIO_AW = $clog2(AUDIO_DEPTH);
   localparam int AUDIO_FW = $clog2(AUDIO_DEPTH + 1);
   localparam int VIDEO_AW = $clog2(VIDEO_DEPTH);
   localparam int VIDEO_FW = $clog2(VIDEO_DEPTH + 1);

   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd40;

   localparam logic [1:0] OP_PUSH_AUDIO = 2'd0;
   localparam logic [1:0] OP_PUSH_VIDEO = 2'd1;
   localparam logic [1:0] OP_SYNC       = 2'd2;

   localparam logic [1:0] STATUS_PUSHED  = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_SYNCED  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY   = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   payload_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               has_image;
      logic [STAMP_W-1:0] audio_stamp;
      logic [TAG_W-1:0]   audio_tag;
      logic [STAMP_W-1:0] image_stamp;
      logic [TAG_W-1:0]   image_tag;
   } rsp_type;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

endpackage

// ----- rtl/core/av_timestamp_synchronizer_top.sv -----
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_type: opcode, stamp, payload_tag
// rsp      out        rsp_valid/rsp_stall   rsp_type: status, has_image, audio and image
// csr      in         csr_wr_en             csr_wr_data: acceptable delay in ms
//
// A push, an ignored opcode or a sync on an empty queue is handled in the idle state.
// A sync enters the compare state and discards stale video frames there until it finishes,
// since one subtract-and-compare unit examines one frame head per cycle.
// Synchronous reset empties both queues, sets the delay to 40 and clears the output valid.
// A request is taken while a finished result waits, if that result drains in that cycle.
module av_timestamp_synchronizer_top
   import avts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [DELAY_W-1:0] csr_wr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CMP  = 1'b1;

   logic               state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [DELAY_W-1:0] delay_ff;

   logic [AUDIO_AW-1:0] audio_rd_ptr_ff, audio_rd_ptr_in;
   logic [AUDIO_FW-1:0] audio_fill_ff, audio_fill_in;
   logic [VIDEO_AW-1:0] video_rd_ptr_ff, video_rd_ptr_in;
   logic [VIDEO_FW-1:0] video_fill_ff, video_fill_in;

   entry_type audio_mem [AUDIO_DEPTH];
   entry_type video_mem [VIDEO_DEPTH];
   entry_type audio_head_ff;
   entry_type video_head_ff;
   entry_type push_entry;

   logic                audio_push;
   logic                video_push;
   logic [AUDIO_AW:0]   audio_wr_sum;
   logic [VIDEO_AW:0]   video_wr_sum;
   logic [AUDIO_AW-1:0] audio_wr_addr;
   logic [VIDEO_AW-1:0] video_wr_addr;
   logic [AUDIO_AW-1:0] audio_ptr_next;
   logic [VIDEO_AW-1:0] video_ptr_next;

   logic                req_accept;
   logic                rsp_free;
   logic signed [STAMP_W:0] diff;
   logic signed [STAMP_W:0] delay_ext;
   logic                video_ahead;
   logic                audio_ahead;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign push_entry.stamp = req_data.stamp;
   assign push_entry.tag   = TAG_BITS'(req_data.payload_tag);

   // The write address wraps once at most, since the head pointer is below the depth and the
   // fill is at most the depth.
   always_comb begin
      audio_wr_sum = (AUDIO_AW + 1)'(audio_rd_ptr_ff) + (AUDIO_AW + 1)'(audio_fill_ff);
      if (audio_wr_sum >= (AUDIO_AW + 1)'(AUDIO_DEPTH)) begin
         audio_wr_addr = AUDIO_AW'(audio_wr_sum - (AUDIO_AW + 1)'(AUDIO_DEPTH));
      end else begin
         audio_wr_addr = AUDIO_AW'(audio_wr_sum);
      end
      video_wr_sum = (VIDEO_AW + 1)'(video_rd_ptr_ff) + (VIDEO_AW + 1)'(video_fill_ff);
      if (video_wr_sum >= (VIDEO_AW + 1)'(VIDEO_DEPTH)) begin
         video_wr_addr = VIDEO_AW'(video_wr_sum - (VIDEO_AW + 1)'(VIDEO_DEPTH));
      end else begin
         video_wr_addr = VIDEO_AW'(video_wr_sum);
      end
      audio_ptr_next = (audio_rd_ptr_ff == AUDIO_AW'(AUDIO_DEPTH - 1)) ?
                       '0 : audio_rd_ptr_ff + AUDIO_AW'(1);
      video_ptr_next = (video_rd_ptr_ff == VIDEO_AW'(VIDEO_DEPTH - 1)) ?
                       '0 : video_rd_ptr_ff + VIDEO_AW'(1);
   end

   always_comb begin
      diff        = $signed({1'b0, audio_head_ff.stamp}) - $signed({1'b0, video_head_ff.stamp});
      delay_ext   = $signed({{(STAMP_W + 1 - DELAY_W){1'b0}}, delay_ff});
      audio_ahead = diff > delay_ext;
      video_ahead = diff < -delay_ext;
   end

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      audio_rd_ptr_in = audio_rd_ptr_ff;
      audio_fill_in   = audio_fill_ff;
      video_rd_ptr_in = video_rd_ptr_ff;
      video_fill_in   = video_fill_ff;
      audio_push      = 1'b0;
      video_push      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.opcode)
                  OP_PUSH_AUDIO: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     if (audio_fill_ff == AUDIO_FW'(AUDIO_DEPTH)) begin
                        rsp_data_in.status = STATUS_DROPPED;
                     end else begin
                        rsp_data_in.status = STATUS_PUSHED;
                        audio_push         = 1'b1;
                        audio_fill_in      = audio_fill_ff + AUDIO_FW'(1);
                     end
                  end
                  OP_PUSH_VIDEO: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     if (video_fill_ff == VIDEO_FW'(VIDEO_DEPTH)) begin
                        rsp_data_in.status = STATUS_DROPPED;
                     end else begin
                        rsp_data_in.status = STATUS_PUSHED;
                        video_push         = 1'b1;
                        video_fill_in      = video_fill_ff + VIDEO_FW'(1);
                     end
                  end
                  OP_SYNC: begin
                     if (audio_fill_ff == '0 || video_fill_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in        = '0;
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_CMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CMP: begin
            rsp_data_in.status      = STATUS_SYNCED;
            rsp_data_in.audio_stamp = audio_head_ff.stamp;
            rsp_data_in.audio_tag   = TAG_W'(audio_head_ff.tag);
            rsp_data_in.image_stamp = video_head_ff.stamp;
            rsp_data_in.image_tag   = TAG_W'(video_head_ff.tag);
            rsp_data_in.has_image   = 1'b0;
            priority if (video_ahead) begin
               rsp_valid_in    = 1'b1;
               audio_rd_ptr_in = audio_ptr_next;
               audio_fill_in   = audio_fill_ff - AUDIO_FW'(1);
               state_in        = ST_IDLE;
            end else if (audio_ahead) begin
               video_rd_ptr_in = video_ptr_next;
               video_fill_in   = video_fill_ff - VIDEO_FW'(1);
               if (video_fill_ff == VIDEO_FW'(1)) begin
                  rsp_valid_in    = 1'b1;
                  audio_rd_ptr_in = audio_ptr_next;
                  audio_fill_in   = audio_fill_ff - AUDIO_FW'(1);
                  state_in        = ST_IDLE;
               end
            end else begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.has_image = 1'b1;
               video_rd_ptr_in       = video_ptr_next;
               video_fill_in         = video_fill_ff - VIDEO_FW'(1);
               audio_rd_ptr_in       = audio_ptr_next;
               audio_fill_in         = audio_fill_ff - AUDIO_FW'(1);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         delay_ff        <= DELAY_RESET;
         audio_rd_ptr_ff <= '0;
         audio_fill_ff   <= '0;
         video_rd_ptr_ff <= '0;
         video_fill_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         audio_rd_ptr_ff <= audio_rd_ptr_in;
         audio_fill_ff   <= audio_fill_in;
         video_rd_ptr_ff <= video_rd_ptr_in;
         video_fill_ff   <= video_fill_in;
         if (csr_wr_en) begin
            delay_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // The head registers follow the next head pointer, so each comparison sees the current head.
   always_ff @(posedge clock) begin
      if (audio_push) begin
         audio_mem[audio_wr_addr] <= push_entry;
      end
      audio_head_ff <= audio_mem[audio_rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (video_push) begin
         video_mem[video_wr_addr] <= push_entry;
      end
      video_head_ff <= video_mem[video_rd_ptr_in];
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      audio_fill_ff <= AUDIO_FW'(AUDIO_DEPTH) && video_fill_ff <= VIDEO_FW'(VIDEO_DEPTH))
      else $error("queue fill beyond depth");

   a_cmp_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> !rsp_valid_ff)
      else $error("result pending while a sync is compared");

   a_cmp_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP |-> audio_fill_ff != '0 && video_fill_ff != '0)
      else $error("sync compare with an empty queue");

   a_sync_pops_audio: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMP && state_in == ST_IDLE |=>
      audio_fill_ff == $past(audio_fill_ff) - AUDIO_FW'(1) && rsp_valid_ff)
      else $error("finished sync did not pop audio and emit");
`endif

endmodule
